### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Each use expects a signal named clk, and SFT_ASSERT also rst_n, in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SFT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFT_ASSERT(lbl, prop, msg)
`define SFT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### hw/rtl/sft_pkg.sv
package sft_pkg;

  // milliseconds per second, the numerator of the frame period
  localparam logic [9:0] MS_PER_SECOND = 10'd1000;

  // divider geometry
  localparam int DVD_W  = 32;   // dividend / quotient width
  localparam int DVS_W  = 26;   // divisor / remainder width (max length < 2^26)
  localparam int STEP_W = 6;    // holds a step count up to DVD_W

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_RATE  = 2'd0;
  localparam logic [1:0] CFG_FRAME_COUNT = 2'd1;
  localparam logic [1:0] CFG_PLAY_ENABLE = 2'd2;
  localparam logic [1:0] CFG_LOOP_ENABLE = 2'd3;

  // request into the shared divider
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;     // number of quotient bits to produce
    logic [DVD_W-1:0]  dividend;  // left aligned: the top 'steps' bits are used
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  // response from the shared divider
  typedef struct packed {
    logic             done;       // one-cycle pulse, results valid with it
    logic [DVD_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

endpackage

### hw/rtl/sft_divider.sv
`include "assert_macros.svh"

module sft_divider
  import sft_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r,  busy_nxt;
  logic              done_r,  done_nxt;
  logic [STEP_W-1:0] cnt_r,   cnt_nxt;
  logic [DVD_W-1:0]  dvd_r,   dvd_nxt;
  logic [DVD_W-1:0]  quo_r,   quo_nxt;
  logic [DVS_W-1:0]  rem_r,   rem_nxt;
  logic [DVS_W-1:0]  dvs_r,   dvs_nxt;

  logic [DVS_W:0]    shifted;
  logic [DVS_W:0]    diff;
  logic              fits;

  // one restoring step: bring down the next dividend bit, try subtracting
  always_comb begin
    shifted = {rem_r, dvd_r[DVD_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    fits    = (shifted >= {1'b0, dvs_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      quo_nxt  = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      rem_nxt = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

  `SFT_ASSERT(a_no_restart, req.start |-> !busy_r, "divider started while busy")
  `SFT_ASSERT(a_busy_count, busy_r |-> (cnt_r != '0), "divider busy with zero step count")
  `SFT_ASSERT(a_rem_below, done_r |-> (rem_r < dvs_r), "remainder not below divisor")

endmodule

### hw/rtl/sprite_frame_timer.sv
// Sprite animation frame timer.
// Input channel (in_valid/in_ready, in_delta_ms): one beat per tick, carrying
// the milliseconds elapsed since the previous tick.
// Output channel (out_valid/out_ready): one beat per tick with the frame
// index, its valid flag and the current time in milliseconds.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always
// ready; index 0 frame rate, 1 frame count, 2 play enable, 3 loop enable.
// Each tick runs through one shared bit-serial divider up to three times: the
// frame period (10 steps), time modulo loop length (32 steps) and the frame
// index (26 steps). A zero frame rate skips the divider; a zero period or
// frame count skips the modulo and index division, and the modulo division
// runs only when the time wraps. in_ready is high only while the sequencer
// is idle, so a new tick is taken only once the previous one is finished.
// The result sits in an output register; a new tick may be accepted while it
// waits, and the sequencer holds its next result until out_ready takes the
// old one.
// Reset (rst_n low, synchronous) clears the time to zero and restores the
// registers to 10 frames/s, 1 frame, play and loop enabled.
`include "assert_macros.svh"

module sprite_frame_timer
  import sft_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_delta_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_frame_valid,
  output logic [15:0] out_frame_index,
  output logic [31:0] out_time_ms,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PER  = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_ADD  = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_MOD  = 4'd5;
  localparam logic [3:0] S_IDXS = 4'd6;
  localparam logic [3:0] S_IDX  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]       state_r,      state_nxt;
  logic [9:0]       rate_r;
  logic [15:0]      count_r;
  logic             play_r;
  logic             loop_r;
  logic [31:0]      elapsed_r,    elapsed_nxt;
  logic [15:0]      delta_r,      delta_nxt;
  logic [9:0]       period_r,     period_nxt;
  logic [DVS_W-1:0] len_r,        len_nxt;
  logic [31:0]      sum_r,        sum_nxt;
  logic [DVS_W-1:0] t_r,          t_nxt;
  logic             res_valid_r,  res_valid_nxt;
  logic [15:0]      res_index_r,  res_index_nxt;
  logic             out_valid_r,  out_valid_nxt;
  logic             out_fv_r,     out_fv_nxt;
  logic [15:0]      out_idx_r,    out_idx_nxt;
  logic [31:0]      out_time_r,   out_time_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_beat;
  logic div_waiting;

  assign in_ready  = (state_r == S_IDLE);
  assign in_beat   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // states that wait on a divider result
  assign div_waiting = (state_r == S_PER) || (state_r == S_MOD) || (state_r == S_IDX);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= 10'd10;
      count_r <= 16'd1;
      play_r  <= 1'b1;
      loop_r  <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_RATE:  rate_r  <= cfg_data[9:0];
        CFG_FRAME_COUNT: count_r <= cfg_data;
        CFG_PLAY_ENABLE: play_r  <= cfg_data[0];
        CFG_LOOP_ENABLE: loop_r  <= cfg_data[0];
        default:         rate_r  <= rate_r;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    elapsed_nxt   = elapsed_r;
    delta_nxt     = delta_r;
    period_nxt    = period_r;
    len_nxt       = len_r;
    sum_nxt       = sum_r;
    t_nxt         = t_r;
    res_valid_nxt = res_valid_r;
    res_index_nxt = res_index_r;
    out_valid_nxt = out_valid_r;
    out_fv_nxt    = out_fv_r;
    out_idx_nxt   = out_idx_r;
    out_time_nxt  = out_time_r;
    div_req       = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          delta_nxt = in_delta_ms;
          if (rate_r == 10'd0) begin
            // no period at all: zero-length loop
            res_valid_nxt = 1'b0;
            res_index_nxt = '0;
            state_nxt     = S_OUT;
          end else begin
            div_req.start    = 1'b1;
            div_req.steps    = STEP_W'(10);
            div_req.dividend = {MS_PER_SECOND, 22'd0};
            div_req.divisor  = DVS_W'(rate_r);
            state_nxt        = S_PER;
          end
        end
      end
      S_PER: begin
        if (div_rsp.done) begin
          period_nxt = div_rsp.quotient[9:0];
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        len_nxt   = DVS_W'(period_r) * DVS_W'(count_r);
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (len_r == '0) begin
          res_valid_nxt = 1'b0;
          res_index_nxt = '0;
          state_nxt     = S_OUT;
        end else begin
          sum_nxt   = elapsed_r + (play_r ? {16'd0, delta_r} : 32'd0);
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        // clamp, pass through, or wrap by division
        priority if (sum_r < {6'd0, len_r}) begin
          t_nxt     = sum_r[DVS_W-1:0];
          state_nxt = S_IDXS;
        end else if (!loop_r) begin
          t_nxt     = len_r - DVS_W'(1);
          state_nxt = S_IDXS;
        end else begin
          div_req.start    = 1'b1;
          div_req.steps    = STEP_W'(DVD_W);
          div_req.dividend = sum_r;
          div_req.divisor  = len_r;
          state_nxt        = S_MOD;
        end
      end
      S_MOD: begin
        if (div_rsp.done) begin
          t_nxt     = div_rsp.remainder;
          state_nxt = S_IDXS;
        end
      end
      S_IDXS: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEP_W'(DVS_W);
        div_req.dividend = {t_r, 6'd0};
        div_req.divisor  = DVS_W'(period_r);
        state_nxt        = S_IDX;
      end
      S_IDX: begin
        if (div_rsp.done) begin
          res_valid_nxt = 1'b1;
          res_index_nxt = div_rsp.quotient[15:0];
          elapsed_nxt   = {6'd0, t_r};
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_fv_nxt    = res_valid_r;
          out_idx_nxt   = res_index_r;
          out_time_nxt  = elapsed_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    delta_r     <= delta_nxt;
    period_r    <= period_nxt;
    len_r       <= len_nxt;
    sum_r       <= sum_nxt;
    t_r         <= t_nxt;
    res_valid_r <= res_valid_nxt;
    res_index_r <= res_index_nxt;
    out_fv_r    <= out_fv_nxt;
    out_idx_r   <= out_idx_nxt;
    out_time_r  <= out_time_nxt;
  end

  sft_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_valid       = out_valid_r;
  assign out_frame_valid = out_fv_r;
  assign out_frame_index = out_idx_r;
  assign out_time_ms     = out_time_r;

  `SFT_ASSERT(a_beat_leaves_idle, in_beat |=> (state_r != S_IDLE), "tick beat did not start work")
  `SFT_ASSERT(a_done_when_waiting, div_rsp.done |-> div_waiting, "divider result with no one waiting")
  `SFT_ASSERT(a_invalid_index_zero, (out_valid_r && !out_fv_r) |-> (out_idx_r == '0), "nonzero index")

endmodule
